### design/gcr_pkg.sv
// ----------------------------------------------------------------------------
// gcr_pkg
// Shared types and constants for the streaming GF(2) column rank block.
// ----------------------------------------------------------------------------
`default_nettype none

package gcr_pkg;

    localparam int COL_W  = 30;
    localparam int RANK_W = 5;

    localparam logic [RANK_W-1:0] RANK_LIMIT = 5'd31;

    typedef enum logic
    {
        GCR_IDLE,
        GCR_SCAN
    } gcr_state_t;

    typedef struct packed
    {
        logic load;
        logic step;
        logic publish;
    } gcr_cmd_t;

    typedef struct packed
    {
        logic done;
    } gcr_status_t;

endpackage

`default_nettype wire

### design/gcr_if.sv
// ----------------------------------------------------------------------------
// gcr_if
// Valid/ready channels for column beats in and rank result beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface gcr_in_if;
    logic                      valid;
    logic                      ready;
    logic [gcr_pkg::COL_W-1:0] column_bits;
    logic                      first_column;
    logic                      last_column;

    modport source (output valid, output column_bits, output first_column,
                    output last_column, input ready);
    modport sink   (input valid, input column_bits, input first_column,
                    input last_column, output ready);
endinterface

interface gcr_out_if;
    logic                       valid;
    logic                       ready;
    logic [gcr_pkg::RANK_W-1:0] rank_so_far;
    logic                       independent;
    logic                       final_result;

    modport source (output valid, output rank_so_far, output independent,
                    output final_result, input ready);
    modport sink   (input valid, input rank_so_far, input independent,
                    input final_result, output ready);
endinterface

`default_nettype wire

### design/gcr_datapath.sv
// ----------------------------------------------------------------------------
// gcr_datapath
// Echelon basis, working column, running rank and result register. Scans one
// row slot per step from the top down, reducing or storing the column.
// ----------------------------------------------------------------------------
`default_nettype none

module gcr_datapath #(
    parameter int ROW_COUNT = 30
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire  gcr_pkg::gcr_cmd_t          cmd,
    output gcr_pkg::gcr_status_t             status,
    input  wire  [gcr_pkg::COL_W-1:0]        column_bits,
    input  wire                              first_column,
    input  wire                              last_column,
    output logic [gcr_pkg::RANK_W-1:0]       rank_so_far,
    output logic                             independent,
    output logic                             final_result
);

    localparam int COL_W  = gcr_pkg::COL_W;
    localparam int RANK_W = gcr_pkg::RANK_W;
    localparam int SLOTS  = (ROW_COUNT < COL_W) ? ROW_COUNT : COL_W;
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [IDX_W-1:0] TOP_IDX   = IDX_W'(SLOTS - 1);
    localparam logic [COL_W:0]   MASK_WIDE = ((COL_W + 1)'(1) << SLOTS) - (COL_W + 1)'(1);
    localparam logic [COL_W-1:0] ROW_MASK  = MASK_WIDE[COL_W-1:0];

    logic [COL_W-1:0]  value_reg, value_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              indep_reg, indep_next;
    logic              last_reg, last_next;
    logic [RANK_W-1:0] rank_reg, rank_next;
    logic [SLOTS-1:0]  valid_reg, valid_next;
    logic [COL_W-1:0]  basis_reg [SLOTS];

    logic [RANK_W-1:0] rank_out_reg;
    logic              indep_out_reg;
    logic              final_out_reg;

    logic [SLOTS-1:0]  value_slots;
    logic              hit;
    logic              store;

    assign value_slots = value_reg[SLOTS-1:0];
    assign hit         = cmd.step && value_slots[idx_reg];
    assign store       = hit && !valid_reg[idx_reg];
    assign status.done = (value_reg == '0) || indep_reg;

    always_comb
    begin
        value_next = value_reg;
        idx_next   = idx_reg;
        indep_next = indep_reg;
        last_next  = last_reg;
        rank_next  = rank_reg;
        valid_next = valid_reg;
        if (cmd.load)
        begin
            value_next = column_bits & ROW_MASK;
            idx_next   = TOP_IDX;
            indep_next = 1'b0;
            last_next  = last_column;
            if (first_column)
            begin
                valid_next = '0;
                rank_next  = '0;
            end
        end
        else if (cmd.step)
        begin
            idx_next = idx_reg - IDX_W'(1);
            if (hit)
            begin
                if (valid_reg[idx_reg])
                begin
                    value_next = value_reg ^ basis_reg[idx_reg];
                end
                else
                begin
                    valid_next[idx_reg] = 1'b1;
                    indep_next          = 1'b1;
                    if (rank_reg < gcr_pkg::RANK_LIMIT)
                    begin
                        rank_next = rank_reg + RANK_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            indep_reg <= 1'b0;
            rank_reg  <= '0;
            valid_reg <= '0;
        end
        else
        begin
            idx_reg   <= idx_next;
            indep_reg <= indep_next;
            rank_reg  <= rank_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        last_reg  <= last_next;
        if (store)
        begin
            basis_reg[idx_reg] <= value_reg;
        end
        if (cmd.publish)
        begin
            rank_out_reg  <= rank_reg;
            indep_out_reg <= indep_reg;
            final_out_reg <= last_reg;
        end
    end

    assign rank_so_far  = rank_out_reg;
    assign independent  = indep_out_reg;
    assign final_result = final_out_reg;

    // every stored row adds exactly one to the rank
    a_rank_matches_rows: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(rank_reg))
        else $error("rank does not match number of stored rows");

    a_load_restarts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (idx_reg == TOP_IDX) && !indep_reg)
        else $error("scan did not restart at top slot");

    a_step_only_live: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (value_reg != '0) && !indep_reg)
        else $error("step issued on a finished column");

endmodule

`default_nettype wire

### design/gcr_ctrl.sv
// ----------------------------------------------------------------------------
// gcr_ctrl
// Sequencer for one column at a time: load, step until done, publish result.
// Owns the handshakes on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module gcr_ctrl (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   column_valid,
    output logic                  column_ready,
    output logic                  result_valid,
    input  wire                   result_ready,
    input  wire gcr_pkg::gcr_status_t status,
    output gcr_pkg::gcr_cmd_t     cmd
);

    gcr_pkg::gcr_state_t state_reg, state_next;
    logic                out_valid_reg, out_valid_next;
    logic                can_publish;

    assign can_publish = !out_valid_reg || result_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gcr_pkg::GCR_IDLE:
            begin
                if (column_valid)
                begin
                    state_next = gcr_pkg::GCR_SCAN;
                end
            end
            gcr_pkg::GCR_SCAN:
            begin
                if (status.done && can_publish)
                begin
                    state_next = gcr_pkg::GCR_IDLE;
                end
            end
            default:
            begin
                state_next = gcr_pkg::GCR_IDLE;
            end
        endcase
    end

    always_comb
    begin
        column_ready = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            gcr_pkg::GCR_IDLE:
            begin
                column_ready = 1'b1;
                cmd.load     = column_valid;
            end
            gcr_pkg::GCR_SCAN:
            begin
                cmd.step    = !status.done;
                // hold the finished column while the result slot is occupied
                cmd.publish = status.done && can_publish;
            end
            default:
            begin
                column_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gcr_pkg::GCR_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

    a_publish_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> status.done)
        else $error("result published before column finished");

    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (column_valid && column_ready) |=> (state_reg == gcr_pkg::GCR_SCAN))
        else $error("accepted beat did not start a scan");

    a_scan_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gcr_pkg::GCR_SCAN && !status.done)
            |=> (state_reg == gcr_pkg::GCR_SCAN) && !column_ready)
        else $error("scan left before column finished");

endmodule

`default_nettype wire

### design/gf2_column_rank.sv
// ----------------------------------------------------------------------------
// gf2_column_rank
// Streaming GF(2) rank: reduces each column against an echelon basis.
// ----------------------------------------------------------------------------
// One column beat is taken at a time and gives one result beat. After the
// beat is accepted the datapath walks the row slots from the top down, one
// slot per cycle: where the working column has a set bit it XORs in the stored
// row for that slot, or stores the column in an empty slot and bumps the rank.
// The walk stops early once the column is zero or stored. The slots are
// scanned in turn over the shared XOR unit, and a finished column waits for
// the output register to be free or being read before it is published. A
// column marked first clears the basis and rank at once. The result sits in
// an output register, so a stalled result does not stop the next column
// from being taken. Column bits at or above ROW_COUNT are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module gf2_column_rank #(
    parameter int ROW_COUNT = 30
) (
    input  wire        clk,
    input  wire        rst_n,
    gcr_in_if.sink     column,
    gcr_out_if.source  result
);

    gcr_pkg::gcr_cmd_t    cmd;
    gcr_pkg::gcr_status_t status;

    gcr_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .column_valid (column.valid),
        .column_ready (column.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .status       (status),
        .cmd          (cmd)
    );

    gcr_datapath #(
        .ROW_COUNT (ROW_COUNT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .column_bits  (column.column_bits),
        .first_column (column.first_column),
        .last_column  (column.last_column),
        .rank_so_far  (result.rank_so_far),
        .independent  (result.independent),
        .final_result (result.final_result)
    );

endmodule

`default_nettype wire
